>>> rtl/stimulus_step_ramp_sequencer_top_defines.svh
// Assertion macros used by the sequencer checker.
`ifndef STIMULUS_STEP_RAMP_SEQUENCER_TOP_DEFINES_SVH
`define STIMULUS_STEP_RAMP_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define SSRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SSRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ssrs_pkg.sv
// Shared types, constants and register codes of the stimulus sequencer.
package ssrs_pkg;

  localparam int MAX_STEPS  = 256;
  localparam int TIME_BITS  = 48;
  localparam int IDX_BITS   = $clog2(MAX_STEPS);
  localparam int CMD_BITS   = 40;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_AMPLITUDE   = 4'd0,
    REG_AMPLITUDE_STEP  = 4'd1,
    REG_STEP_COUNT      = 4'd2,
    REG_GAP_TICKS       = 4'd3,
    REG_WIDTH_TICKS     = 4'd4,
    REG_REPEAT_COUNT    = 4'd5,
    REG_RAMP_MODE       = 4'd6,
    REG_RAMP_SLOPE_STEP = 4'd7
  } reg_idx_t;

  // Spike report status codes
  localparam logic [1:0] RATE_NONE  = 2'd0;
  localparam logic [1:0] RATE_ONE   = 2'd1;
  localparam logic [1:0] RATE_VALID = 2'd2;

  typedef struct packed {
    logic signed [27:0] min_amplitude;
    logic [26:0]        amplitude_step;
    logic [8:0]         step_count;
    logic [31:0]        gap_ticks;
    logic [31:0]        width_ticks;
    logic [15:0]        repeat_count;
    logic               ramp_mode;
    logic [23:0]        ramp_slope_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_amplitude:   -28'sd100000,
    amplitude_step:  27'd50000,
    step_count:      9'd11,
    gap_ticks:       32'd20000,
    width_ticks:     32'd10000,
    repeat_count:    16'd1,
    ramp_mode:       1'b0,
    ramp_slope_step: 24'd10
  };

  typedef struct packed {
    logic [TIME_BITS-1:0]       tick_time;
    logic [TIME_BITS-1:0]       window_start;
    logic [IDX_BITS-1:0]        step_index;
    logic [15:0]                cycle_index;
    logic signed [CMD_BITS-1:0] command_level;
    logic [15:0]                spikes_seen;
    logic [TIME_BITS-1:0]       first_spike_time;
    logic [TIME_BITS-1:0]       last_spike_time;
  } state_t;

  typedef struct packed {
    logic signed [CMD_BITS-1:0] command;
    logic                       step_done;
    logic signed [CMD_BITS-1:0] done_amplitude;
    logic [15:0]                spike_total;
    logic [31:0]                spike_span;
    logic [1:0]                 rate_status;
    logic [15:0]                cycle_number;
    logic [7:0]                 step_number;
    logic                       protocol_done;
  } result_t;

endpackage

>>> rtl/ssrs_ifs.sv
// Handshake channel interfaces: sample requests, results and register writes.
interface ssrs_sample_if;
  logic valid;
  logic ready;
  logic spike;
  logic restart;
  modport source (output valid, spike, restart, input ready);
  modport sink   (input valid, spike, restart, output ready);
endinterface

interface ssrs_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [ssrs_pkg::CMD_BITS-1:0] command;
  logic                                step_done;
  logic signed [ssrs_pkg::CMD_BITS-1:0] done_amplitude;
  logic [15:0]                         spike_total;
  logic [31:0]                         spike_span;
  logic [1:0]                          rate_status;
  logic [15:0]                         cycle_number;
  logic [7:0]                          step_number;
  logic                                protocol_done;
  modport source (output valid, command, step_done, done_amplitude, spike_total,
                  spike_span, rate_status, cycle_number, step_number, protocol_done,
                  input ready);
  modport sink   (input valid, command, step_done, done_amplitude, spike_total,
                  spike_span, rate_status, cycle_number, step_number, protocol_done,
                  output ready);
endinterface

interface ssrs_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ssrs_pkg::CFG_IDX_BITS-1:0]     index;
  logic [ssrs_pkg::CFG_DATA_BITS-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/ssrs_tick.sv
// Per-tick sequencer update: window timing, command level and spike report.
module ssrs_tick (
  input  ssrs_pkg::cfg_t    cfg,
  input  ssrs_pkg::state_t  st,
  input  logic              spike,
  input  logic              restart,
  output ssrs_pkg::state_t  st_next,
  output ssrs_pkg::result_t res
);

  localparam int TB       = ssrs_pkg::TIME_BITS;
  localparam int IB       = ssrs_pkg::IDX_BITS;
  localparam int CB       = ssrs_pkg::CMD_BITS;
  localparam int NSTEP_W  = (IB + 1 > 9) ? IB + 1 : 9;
  localparam int AMP_W    = IB + 29;
  localparam int SAT_W    = (AMP_W > CB + 2) ? AMP_W : CB + 2;
  localparam logic signed [SAT_W-1:0] CMD_HI =
    SAT_W'(signed'({1'b0, {(CB-1){1'b1}}}));
  localparam logic signed [SAT_W-1:0] CMD_LO =
    SAT_W'(signed'({1'b1, {(CB-1){1'b0}}}));
  localparam logic [NSTEP_W-1:0] STEP_LIMIT = NSTEP_W'(ssrs_pkg::MAX_STEPS);

  // clamp a wide signed sum into the command range
  function automatic logic signed [CB-1:0] sat_cmd(input logic signed [SAT_W-1:0] v);
    logic signed [CB-1:0] r;
    if (v > CMD_HI) begin
      r = CMD_HI[CB-1:0];
    end else if (v < CMD_LO) begin
      r = CMD_LO[CB-1:0];
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  ssrs_pkg::state_t     cur;
  logic [NSTEP_W-1:0]   nsteps;
  logic [NSTEP_W-1:0]   idx_ext;
  logic [NSTEP_W-1:0]   idx_after;
  logic [IB+26:0]       amp_prod;
  logic [IB+23:0]       ramp_inc;
  logic signed [SAT_W-1:0] amp_sum;
  logic signed [SAT_W-1:0] ramp_up;
  logic signed [SAT_W-1:0] ramp_dn;
  logic signed [CB-1:0] step_amp;
  logic [TB:0]          win_end;
  logic [TB:0]          win_half;
  logic                 in_win;
  logic                 past_win;
  logic                 rising;
  logic [TB-1:0]        span_wide;

  always_comb begin
    // restart takes effect before this tick is processed
    cur = st;
    if (restart) begin
      cur = '0;
      cur.window_start = TB'(cfg.gap_ticks);
    end

    nsteps = (NSTEP_W'(cfg.step_count) > STEP_LIMIT) ? STEP_LIMIT
                                                      : NSTEP_W'(cfg.step_count);
    idx_ext   = NSTEP_W'(cur.step_index);
    idx_after = idx_ext;

    // amplitude and ramp increment for the current step
    amp_prod = (IB+27)'(cur.step_index) * (IB+27)'(cfg.amplitude_step);
    ramp_inc = (IB+24)'(cur.step_index) * (IB+24)'(cfg.ramp_slope_step);
    amp_sum  = SAT_W'(cfg.min_amplitude) + SAT_W'(signed'({1'b0, amp_prod}));
    step_amp = sat_cmd(amp_sum);
    ramp_up  = SAT_W'(cur.command_level) + SAT_W'(signed'({1'b0, ramp_inc}));
    ramp_dn  = SAT_W'(cur.command_level) - SAT_W'(signed'({1'b0, ramp_inc}));

    // window bounds, one bit wider so they never wrap
    win_end  = {1'b0, cur.window_start} + (TB+1)'(cfg.width_ticks);
    win_half = {1'b0, cur.window_start} + (TB+1)'(cfg.width_ticks >> 1);
    in_win   = (cur.tick_time >= cur.window_start) && ({1'b0, cur.tick_time} < win_end);
    past_win = {1'b0, cur.tick_time} >= win_end;
    rising   = {1'b0, cur.tick_time} < win_half;

    span_wide = cur.last_spike_time - cur.first_spike_time;

    st_next = cur;
    res     = '0;

    if (cur.cycle_index < cfg.repeat_count) begin
      if (idx_ext < nsteps) begin
        if (in_win) begin
          if (!cfg.ramp_mode) begin
            st_next.command_level = step_amp;
          end else if (rising) begin
            st_next.command_level = sat_cmd(ramp_up);
          end else begin
            st_next.command_level = sat_cmd(ramp_dn);
          end
          if (spike) begin
            if (cur.spikes_seen == '0) begin
              st_next.first_spike_time = cur.tick_time;
            end
            st_next.last_spike_time = cur.tick_time;
            if (cur.spikes_seen != '1) begin
              st_next.spikes_seen = cur.spikes_seen + 16'd1;
            end
          end
        end else if (past_win) begin
          // window-end tick: report and move on to the next step
          res.step_done      = 1'b1;
          res.done_amplitude = step_amp;
          res.spike_total    = cur.spikes_seen;
          if (cur.spikes_seen >= 16'd2) begin
            res.rate_status = ssrs_pkg::RATE_VALID;
            res.spike_span  = (span_wide > TB'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                : 32'(span_wide);
          end else if (cur.spikes_seen == 16'd1) begin
            res.rate_status = ssrs_pkg::RATE_ONE;
          end else begin
            res.rate_status = ssrs_pkg::RATE_NONE;
          end
          st_next.window_start = cur.window_start + TB'(cfg.gap_ticks)
                                 + TB'(cfg.width_ticks);
          st_next.spikes_seen      = '0;
          st_next.first_spike_time = '0;
          st_next.last_spike_time  = '0;
          st_next.command_level    = '0;
          idx_after = idx_ext + NSTEP_W'(1);
        end else begin
          st_next.command_level = '0;
        end
      end
      // cycle wraps once the step index reaches the step count
      if (idx_after >= nsteps) begin
        st_next.cycle_index = cur.cycle_index + 16'd1;
        idx_after = '0;
      end
      st_next.step_index = idx_after[IB-1:0];
    end

    st_next.tick_time = cur.tick_time + TB'(1);

    res.command       = st_next.command_level;
    res.cycle_number  = st_next.cycle_index;
    res.step_number   = 8'(st_next.step_index);
    res.protocol_done = st_next.cycle_index >= cfg.repeat_count;
  end

endmodule

>>> rtl/stimulus_step_ramp_sequencer_top.sv
// Top level of the step / ramp stimulus sequencer with spike report.
//
//   channel  dir  handshake     contents
//   sample   in   valid/ready   spike, restart (one request per sample tick)
//   result   out  valid/ready   command, window-end report, cycle/step position
//   cfg      in   valid/ready   register index, write data (always ready)
//
// One request enters per cycle while the result is not stalled; its result passes through
// the input register, then the tick update into the result register, before it is offered.
// Sequencer state is updated in the same cycle the result register loads, so
// consecutive ticks flow back to back.
// A stalled result holds the result register, and the input register then fills
// and holds; ready drops only when both are occupied.
// Synchronous reset clears the pipeline and loads the register reset values.
module stimulus_step_ramp_sequencer_top (
  input  logic          clk,
  input  logic          rst,
  ssrs_sample_if.sink   sample,
  ssrs_result_if.source result,
  ssrs_cfg_if.sink      cfg
);

  ssrs_pkg::cfg_t    regs;
  ssrs_pkg::state_t  st;
  ssrs_pkg::state_t  st_next;
  ssrs_pkg::result_t res;
  ssrs_pkg::result_t res_q;

  logic in_valid;
  logic in_spike;
  logic in_restart;
  logic out_valid;
  logic out_free;
  logic advance;

  assign out_free     = !out_valid || result.ready;
  assign advance      = in_valid && out_free;
  assign sample.ready = !in_valid || out_free;
  assign cfg.ready    = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= ssrs_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ssrs_pkg::REG_MIN_AMPLITUDE:   regs.min_amplitude   <= cfg.data[27:0];
        ssrs_pkg::REG_AMPLITUDE_STEP:  regs.amplitude_step  <= cfg.data[26:0];
        ssrs_pkg::REG_STEP_COUNT:      regs.step_count      <= cfg.data[8:0];
        ssrs_pkg::REG_GAP_TICKS:       regs.gap_ticks       <= cfg.data;
        ssrs_pkg::REG_WIDTH_TICKS:     regs.width_ticks     <= cfg.data;
        ssrs_pkg::REG_REPEAT_COUNT:    regs.repeat_count    <= cfg.data[15:0];
        ssrs_pkg::REG_RAMP_MODE:       regs.ramp_mode       <= cfg.data[0];
        ssrs_pkg::REG_RAMP_SLOPE_STEP: regs.ramp_slope_step <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_spike   <= sample.spike;
      in_restart <= sample.restart;
    end
  end

  ssrs_tick u_tick (
    .cfg     (regs),
    .st      (st),
    .spike   (in_spike),
    .restart (in_restart),
    .st_next (st_next),
    .res     (res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{window_start: ssrs_pkg::TIME_BITS'(ssrs_pkg::CFG_RESET.gap_ticks),
              default: '0};
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign result.valid          = out_valid;
  assign result.command        = res_q.command;
  assign result.step_done      = res_q.step_done;
  assign result.done_amplitude = res_q.done_amplitude;
  assign result.spike_total    = res_q.spike_total;
  assign result.spike_span     = res_q.spike_span;
  assign result.rate_status    = res_q.rate_status;
  assign result.cycle_number   = res_q.cycle_number;
  assign result.step_number    = res_q.step_number;
  assign result.protocol_done  = res_q.protocol_done;

endmodule

>>> rtl/ssrs_checker.sv
// Port-level checks on the sequencer result stream, bound to the top level.
`include "stimulus_step_ramp_sequencer_top_defines.svh"

module ssrs_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ssrs_pkg::CMD_BITS-1:0] command,
  input logic                                 step_done,
  input logic signed [ssrs_pkg::CMD_BITS-1:0] done_amplitude,
  input logic [15:0]                          spike_total,
  input logic [31:0]                          spike_span,
  input logic [1:0]                           rate_status,
  input logic [15:0]                          cycle_number,
  input logic [7:0]                           step_number,
  input logic                                 protocol_done
);

  logic status_ok;
  logic quiet_report;
  logic span_ok;
  logic stalled;
  logic [2*ssrs_pkg::CMD_BITS+75:0] payload;

  // status must match the reported count on a window end
  assign status_ok =
    (spike_total == 16'd0 && rate_status == ssrs_pkg::RATE_NONE) ||
    (spike_total == 16'd1 && rate_status == ssrs_pkg::RATE_ONE) ||
    (spike_total >= 16'd2 && rate_status == ssrs_pkg::RATE_VALID);

  // report fields stay zero away from a window end
  assign quiet_report = (done_amplitude == '0) && (spike_total == '0) &&
                        (spike_span == '0) && (rate_status == ssrs_pkg::RATE_NONE);

  // a span only exists with two or more spikes
  assign span_ok = (rate_status == ssrs_pkg::RATE_VALID) || (spike_span == '0);

  assign stalled = out_valid && !out_ready;
  assign payload = {command, step_done, done_amplitude, spike_total, spike_span,
                    rate_status, cycle_number, step_number, protocol_done};

  `SSRS_ASSERT_IMPLY(a_status, clk, rst, out_valid && step_done, status_ok, "status mismatch")
  `SSRS_ASSERT_IMPLY(a_quiet, clk, rst, out_valid && !step_done, quiet_report, "stray report")
  `SSRS_ASSERT_IMPLY(a_span, clk, rst, out_valid, span_ok, "span without two spikes")
  `SSRS_ASSERT_NEXT(a_hold, clk, rst, stalled, out_valid && $stable(payload), "result moved")

endmodule

bind stimulus_step_ramp_sequencer_top ssrs_checker u_ssrs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .command        (result.command),
  .step_done      (result.step_done),
  .done_amplitude (result.done_amplitude),
  .spike_total    (result.spike_total),
  .spike_span     (result.spike_span),
  .rate_status    (result.rate_status),
  .cycle_number   (result.cycle_number),
  .step_number    (result.step_number),
  .protocol_done  (result.protocol_done)
);

>>> tb/sv/testbench.sv
// Testbench of the stimulus step / ramp sequencer: directed and random sample requests.
`timescale 1ns / 1ps

module testbench;

  localparam int          TIME_W      = ssrs_pkg::TIME_BITS;
  localparam int          CMD_W       = ssrs_pkg::CMD_BITS;
  localparam int          HOLD_CYCLES = 64;
  localparam int          END_WAIT    = 8;
  localparam int          MAX_REPORTS = 10;
  localparam int          PHASE_TICKS = 20;
  localparam int          TOP_STEP    = 255;
  localparam int          RAMP_RISE   = 135;
  localparam int          RAMP_FALL   = 260;
  localparam int          DENSE_WIDTH = 64;
  localparam logic [3:0]  REG_UNUSED  = 4'd8;
  localparam longint      LEVEL_MAX   = (longint'(1) <<< (CMD_W - 1)) - 1;
  localparam longint      LEVEL_MIN   = -(longint'(1) <<< (CMD_W - 1));

  logic clk = 1'b0;
  logic rst;

  ssrs_sample_if smp_if ();
  ssrs_result_if res_if ();
  ssrs_cfg_if    cfg_if ();

  stimulus_step_ramp_sequencer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #4 clk = ~clk;

  // Register copy of the predictor
  logic signed [27:0] cfg_min_amp;
  logic [26:0]        cfg_amp_step;
  logic [8:0]         cfg_steps;
  logic [31:0]        cfg_gap;
  logic [31:0]        cfg_width;
  logic [15:0]        cfg_repeats;
  logic               cfg_ramp;
  logic [23:0]        cfg_slope;

  // Sequencer state of the predictor
  logic [TIME_W-1:0]    now_tick;
  logic [TIME_W-1:0]    win_start;
  logic [TIME_W-1:0]    spk_first;
  logic [TIME_W-1:0]    spk_last;
  int unsigned          step_idx;
  logic [15:0]          cycle_idx;
  logic [15:0]          spk_count;
  longint               cmd_level;

  ssrs_pkg::result_t tick_reports[$];
  int      mismatches = 0;
  int      sender_calm = 0;
  bit      hold_request = 1'b0;

  function automatic longint clamp40(longint v);
    if (v > LEVEL_MAX) return LEVEL_MAX;
    if (v < LEVEL_MIN) return LEVEL_MIN;
    return v;
  endfunction

  function automatic longint unsigned add_sat64(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  function automatic longint level_for_step(int unsigned i);
    return clamp40(longint'(cfg_min_amp) + longint'(i) * longint'(cfg_amp_step));
  endfunction

  // Protocol back to time zero; first window one gap away
  function automatic void restart_seq();
    now_tick  = '0;
    win_start = TIME_W'(cfg_gap);
    step_idx  = 0;
    cycle_idx = '0;
    cmd_level = 0;
    spk_count = '0;
    spk_first = '0;
    spk_last  = '0;
  endfunction

  function automatic void reset_predictor();
    cfg_min_amp  = -28'sd100000;
    cfg_amp_step = 27'd50000;
    cfg_steps    = 9'd11;
    cfg_gap      = 32'd20000;
    cfg_width    = 32'd10000;
    cfg_repeats  = 16'd1;
    cfg_ramp     = 1'b0;
    cfg_slope    = 24'd10;
    restart_seq();
  endfunction

  function automatic void apply_reg(logic [3:0] idx, logic [31:0] value);
    case (idx)
      ssrs_pkg::REG_MIN_AMPLITUDE:   cfg_min_amp  = value[27:0];
      ssrs_pkg::REG_AMPLITUDE_STEP:  cfg_amp_step = value[26:0];
      ssrs_pkg::REG_STEP_COUNT:      cfg_steps    = value[8:0];
      ssrs_pkg::REG_GAP_TICKS:       cfg_gap      = value;
      ssrs_pkg::REG_WIDTH_TICKS:     cfg_width    = value;
      ssrs_pkg::REG_REPEAT_COUNT:    cfg_repeats  = value[15:0];
      ssrs_pkg::REG_RAMP_MODE:       cfg_ramp     = value[0];
      ssrs_pkg::REG_RAMP_SLOPE_STEP: cfg_slope    = value[23:0];
      default: ;
    endcase
  endfunction

  // One sample tick: advances the state and returns the tick's result
  function automatic ssrs_pkg::result_t sequence_tick(bit spike_in, bit restart_in);
    ssrs_pkg::result_t    r;
    int unsigned          active_steps;
    longint unsigned      t;
    longint unsigned      win_end;
    longint               inc;
    longint               amp;
    logic [TIME_W-1:0]    spread;
    r = '0;
    active_steps = (cfg_steps > ssrs_pkg::MAX_STEPS) ? ssrs_pkg::MAX_STEPS : cfg_steps;
    if (restart_in) restart_seq();
    t = now_tick;
    if (cycle_idx < cfg_repeats) begin
      if (step_idx < active_steps) begin
        win_end = add_sat64(win_start, cfg_width);
        if (t >= win_start && t < win_end) begin
          // inside the window: flat step or triangle
          if (!cfg_ramp) begin
            cmd_level = level_for_step(step_idx);
          end else begin
            inc = longint'(step_idx) * longint'(cfg_slope);
            if (t < add_sat64(win_start, cfg_width >> 1)) cmd_level = clamp40(cmd_level + inc);
            else cmd_level = clamp40(cmd_level - inc);
          end
          if (spike_in) begin
            if (spk_count == 16'd0) spk_first = now_tick;
            spk_last = now_tick;
            if (spk_count != 16'hFFFF) spk_count++;
          end
        end else if (t >= win_end) begin
          // window-end tick: spike report, then on to the next step
          r.step_done = 1'b1;
          amp = level_for_step(step_idx);
          r.done_amplitude = amp[CMD_W-1:0];
          r.spike_total = spk_count;
          if (spk_count >= 16'd2) begin
            spread = spk_last - spk_first;
            r.spike_span = (spread > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : spread[31:0];
            r.rate_status = ssrs_pkg::RATE_VALID;
          end else begin
            r.rate_status = (spk_count == 16'd1) ? ssrs_pkg::RATE_ONE : ssrs_pkg::RATE_NONE;
          end
          win_start = win_start + TIME_W'(cfg_gap) + TIME_W'(cfg_width);
          spk_count = '0;
          spk_first = '0;
          spk_last  = '0;
          step_idx++;
          cmd_level = 0;
        end else begin
          cmd_level = 0;
        end
      end
      if (step_idx >= active_steps) begin
        cycle_idx++;
        step_idx = 0;
      end
    end
    now_tick++;
    r.command       = cmd_level[CMD_W-1:0];
    r.cycle_number  = cycle_idx;
    r.step_number   = step_idx[7:0];
    r.protocol_done = (cycle_idx >= cfg_repeats);
    return r;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(24, 8);
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, value);
  endtask

  // One sample request; expectation queued at acceptance
  task automatic send_sample(bit spike_in, bit restart_in);
    int gap;
    gap = 0;
    if (cfg_if.valid) cfg_if.valid <= 1'b0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else begin
      if ($urandom_range(99) < 3) sender_calm = 40;
      gap = pick_gap();
    end
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_if.valid   <= 1'b1;
    smp_if.spike   <= spike_in;
    smp_if.restart <= restart_in;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
    tick_reports.push_back(sequence_tick(spike_in, restart_in));
  endtask

  task automatic send_random(int count, int spike_pct, int restart_pct);
    for (int i = 0; i < count; i++)
      send_sample($urandom_range(99) < spike_pct, $urandom_range(99) < restart_pct);
  endtask

  // Sender pauses until every outstanding result has come back
  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (tick_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_timing(logic [31:0] gap, logic [31:0] width, logic [31:0] steps,
                            logic [31:0] repeats, logic [31:0] ramp);
    write_reg(ssrs_pkg::REG_GAP_TICKS, gap);
    write_reg(ssrs_pkg::REG_WIDTH_TICKS, width);
    write_reg(ssrs_pkg::REG_STEP_COUNT, steps);
    write_reg(ssrs_pkg::REG_REPEAT_COUNT, repeats);
    write_reg(ssrs_pkg::REG_RAMP_MODE, ramp);
  endtask

  // Reset values: windows far off, idle ticks only, restart midway
  task automatic test_reset_defaults();
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
  endtask

  // Step mode at top amplitudes; windows with none, one and two spikes
  task automatic test_step_windows();
    logic [11:0] spikes;
    spikes = 12'b1011_1001_1000;
    drain_results();
    set_timing(32'd0, 32'd3, 32'd3, 32'd1, 32'd0);
    write_reg(ssrs_pkg::REG_MIN_AMPLITUDE, 32'h07FF_FFFF);
    write_reg(ssrs_pkg::REG_AMPLITUDE_STEP, 32'h07FF_FFFF);
    write_reg(ssrs_pkg::REG_RAMP_SLOPE_STEP, 32'd0);
    for (int i = 0; i < 12; i++) send_sample(spikes[i], i == 0);
  endtask

  // Ramp at steepest slope, zero step count, zero repeats
  task automatic test_ramp_specials();
    drain_results();
    set_timing(32'd1, 32'd2, 32'd2, 32'd2, 32'd1);
    write_reg(ssrs_pkg::REG_MIN_AMPLITUDE, 32'h0800_0000);
    write_reg(ssrs_pkg::REG_AMPLITUDE_STEP, 32'd0);
    write_reg(ssrs_pkg::REG_RAMP_SLOPE_STEP, 32'h00FF_FFFF);
    send_sample(1'b1, 1'b1);
    send_random(6, 50, 0);
    drain_results();
    write_reg(ssrs_pkg::REG_STEP_COUNT, 32'd0);
    send_random(2, 50, 0);
    drain_results();
    write_reg(ssrs_pkg::REG_REPEAT_COUNT, 32'd0);
    send_sample(1'b0, 1'b1);
  endtask

  // Largest gap, width, step count and repeat count
  task automatic test_timing_extremes();
    drain_results();
    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FF, 32'hFFFF, 32'd0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
  endtask

  // Short protocols with random registers and spike density
  task automatic test_random_protocols();
    int roll;
    logic [31:0] width;
    logic [31:0] steps;
    for (int phase = 0; phase < 12; phase++) begin
      drain_results();
      width = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(9, 2);
      roll = $urandom_range(19);
      if (roll == 0) steps = 32'd0;
      else if (roll == 1) steps = $urandom_range(511, 256);
      else steps = $urandom_range(6, 1);
      set_timing($urandom_range(4), width, steps, $urandom_range(3), $urandom_range(1));
      if (phase % 2 == 1) begin
        write_reg(ssrs_pkg::REG_MIN_AMPLITUDE, $urandom());
        write_reg(ssrs_pkg::REG_AMPLITUDE_STEP, $urandom());
        write_reg(ssrs_pkg::REG_RAMP_SLOPE_STEP, $urandom());
      end
      write_reg(REG_UNUSED | 4'($urandom_range(7)), $urandom());
      // long receiver stall while requests keep coming
      if (phase == 3) hold_request = 1'b1;
      send_sample($urandom_range(1), 1'b1);
      send_random(PHASE_TICKS, $urandom_range(80, 5), 2);
    end
  endtask

  // Step count dropped below the current step index mid-cycle
  task automatic test_step_count_lowered();
    drain_results();
    set_timing(32'd1, 32'd2, 32'd6, 32'd2, $urandom_range(1));
    send_sample($urandom_range(1), 1'b1);
    while (step_idx < 4) send_sample($urandom_range(1), 1'b0);
    drain_results();
    write_reg(ssrs_pkg::REG_STEP_COUNT, 32'd2);
    send_random(12, 40, 0);
  endtask

  // Ramp driven into both ends of the command range
  task automatic test_ramp_saturation();
    int unsigned offset;
    drain_results();
    // zero-width windows with no gap move the step index on every tick
    set_timing(32'd0, 32'd0, 32'd256, 32'd1, 32'd1);
    write_reg(ssrs_pkg::REG_RAMP_SLOPE_STEP, 32'h00FF_FFFF);
    send_sample($urandom_range(1), 1'b1);
    while (step_idx < TOP_STEP) send_sample($urandom_range(1), 1'b0);
    drain_results();
    write_reg(ssrs_pkg::REG_WIDTH_TICKS, 32'hFFFF_FFFF);
    send_random(RAMP_RISE, 30, 0);
    drain_results();
    // shrink the window so that the rest of it is the falling half
    offset = 32'(now_tick - win_start);
    write_reg(ssrs_pkg::REG_WIDTH_TICKS, offset + RAMP_FALL);
    send_random(RAMP_FALL + 3, 30, 0);
  endtask

  // Dense spikes across one longer window
  task automatic test_spike_dense();
    drain_results();
    set_timing(32'd0, DENSE_WIDTH, 32'd1, 32'd1, 32'd0);
    send_sample(1'b1, 1'b1);
    send_random(DENSE_WIDTH + 2, 97, 0);
  endtask

  // Result ready: random stalls, calm stretches, one long hold on request
  initial begin : result_ready_driver
    int stall;
    int calm;
    stall = 0;
    calm = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(99) < 3) calm = 50;
        else stall = pick_gap();
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    ssrs_pkg::result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (tick_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: result with no request pending", $time);
      end else begin
        want = tick_reports.pop_front();
        check_field("command", want.command, res_if.command);
        check_field("step_done", want.step_done, res_if.step_done);
        check_field("done_amplitude", want.done_amplitude, res_if.done_amplitude);
        check_field("spike_total", want.spike_total, res_if.spike_total);
        check_field("spike_span", want.spike_span, res_if.spike_span);
        check_field("rate_status", want.rate_status, res_if.rate_status);
        check_field("cycle_number", want.cycle_number, res_if.cycle_number);
        check_field("step_number", want.step_number, res_if.step_number);
        check_field("protocol_done", want.protocol_done, res_if.protocol_done);
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    smp_if.valid   <= 1'b0;
    smp_if.spike   <= 1'b0;
    smp_if.restart <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= ssrs_pkg::REG_MIN_AMPLITUDE;
    cfg_if.data    <= '0;
    reset_predictor();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_step_windows();
    test_ramp_specials();
    test_timing_extremes();
    test_random_protocols();
    test_step_count_lowered();
    test_ramp_saturation();
    test_spike_dense();

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
